### rtl/core/nsp_pkg.sv
package nsp_pkg;

	// One received byte of the sentence stream.
	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_item_t;

	// One parser result.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
		logic [2:0] sentence_type;
		logic [4:0] field_index;
		logic [1:0] status;
	} res_item_t;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_FEND = 2'd1;
	localparam logic [1:0] KIND_SEND = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_CK_BAD    = 2'd1;
	localparam logic [1:0] ST_UNSUPP    = 2'd2;
	localparam logic [1:0] ST_MALFORMED = 2'd3;

	localparam logic [2:0] TYPE_UNKNOWN = 3'd0;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	localparam int NUM_TYPES = 7;

	// Sentence type codes in priority order: GGA, GLL, GSA, GSV, RMC, VTG, ZDA.
	localparam logic [23:0] TYPE_CODES [NUM_TYPES] = '{
		24'h474741, 24'h474C4C, 24'h475341, 24'h475356,
		24'h524D43, 24'h565447, 24'h5A4441
	};

	// Uppercase hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b1, 4'(b - 8'h41 + 8'd10)};
		end
		return r;
	endfunction

endpackage

### rtl/core/nsp_stream_if.sv
interface nsp_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/nmea_sentence_parser_core.sv
// NMEA 0183 sentence parser core.
// The rx channel takes one ASCII byte per item (payload nsp_pkg::rx_item_t). A '$' opens
// a sentence; the address token is scanned for GGA, GLL, GSA, GSV, RMC, VTG and ZDA.
// The res channel carries at most one item per accepted byte (nsp_pkg::res_item_t):
// a field data byte, a field end on each ',' or '*', or a sentence end with status
// after the two checksum digits or a non-hex first one. Bytes outside a sentence
// give no item. A result is presented in the cycle after its byte is accepted,
// straight out of the result register. The core takes one byte per cycle while
// the result register can drain; a single parser state update sits before it.
// Stalls: rx.ready stays high while the result register is empty or is being
// drained in the same cycle; when the receiver holds res.ready low with a result
// pending, rx.ready drops until that result is taken. Bytes that produce no result
// are still gated this way, so ordering is kept trivially.
// Reset (arst_n low, asynchronous) returns the parser to idle, clears the checksum,
// type window, type, field count and error flag, and empties the result register.
// MAX_FIELDS sets where the field counter saturates (capped at 31); a ',' at the
// limit marks the sentence malformed.
module nmea_sentence_parser_core #(
	parameter int MAX_FIELDS = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	nsp_stream_if.sink          rx,
	nsp_stream_if.source        res
);
	import nsp_pkg::*;

	localparam int         CAP_INT   = (MAX_FIELDS < 31) ? MAX_FIELDS : 31;
	localparam logic [4:0] FIELD_CAP = 5'(CAP_INT);

	typedef enum logic [2:0] {
		PH_IDLE, PH_TYPE, PH_FIELDS, PH_CK_HI, PH_CK_LO
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  xor_q, xor_d;
	logic [23:0] window_q, window_d;
	logic [2:0]  found_q, found_d;
	logic [4:0]  fcount_q, fcount_d;
	logic [3:0]  hi_nib_q, hi_nib_d;
	logic        malformed_q, malformed_d;

	logic        out_valid_q;
	res_item_t   res_q;

	logic        accept;
	logic        emit;
	res_item_t   r;
	logic [7:0]  b;
	logic [4:0]  hex;
	logic        hit;
	logic [2:0]  hit_idx;

	// The result register is free when empty or when its item leaves this cycle.
	assign rx.ready  = !out_valid_q || res.ready;
	assign accept    = rx.valid && rx.ready;
	assign res.valid = out_valid_q;
	assign res.data  = res_q;

	always_comb begin
		b           = rx.data.rx_byte;
		hex         = hex_decode(b);
		phase_d     = phase_q;
		xor_d       = xor_q;
		window_d    = window_q;
		found_d     = found_q;
		fcount_d    = fcount_q;
		hi_nib_d    = hi_nib_q;
		malformed_d = malformed_q;
		emit        = 1'b0;
		r           = '0;
		hit         = 1'b0;
		hit_idx     = TYPE_UNKNOWN;

		if (b == CH_DOLLAR) begin
			// A start byte always opens a fresh sentence, dropping any open one.
			phase_d     = PH_TYPE;
			xor_d       = 8'd0;
			window_d    = 24'd0;
			found_d     = TYPE_UNKNOWN;
			fcount_d    = 5'd0;
			hi_nib_d    = 4'd0;
			malformed_d = 1'b0;
		end else begin
			unique case (phase_q)
				PH_TYPE: begin
					if (b == CH_STAR) begin
						phase_d = PH_CK_HI;
						emit    = 1'b1;
						r.kind  = KIND_FEND;
					end else if (b == CH_COMMA) begin
						xor_d    = xor_q ^ b;
						phase_d  = PH_FIELDS;
						fcount_d = 5'd1;
						emit     = 1'b1;
						r.kind   = KIND_FEND;
					end else begin
						xor_d    = xor_q ^ b;
						window_d = {window_q[15:0], b};
						for (int i = 0; i < NUM_TYPES; i++) begin
							if (!hit && window_d == TYPE_CODES[i]) begin
								hit     = 1'b1;
								hit_idx = 3'(i + 1);
							end
						end
						// Keep the highest-priority code seen anywhere in the token.
						if (hit && (found_q == TYPE_UNKNOWN || hit_idx < found_q)) begin
							found_d = hit_idx;
						end
					end
				end
				PH_FIELDS: begin
					emit          = 1'b1;
					r.field_index = fcount_q;
					if (b == CH_STAR) begin
						phase_d = PH_CK_HI;
						r.kind  = KIND_FEND;
					end else if (b == CH_COMMA) begin
						xor_d  = xor_q ^ b;
						r.kind = KIND_FEND;
						if (fcount_q < FIELD_CAP) begin
							fcount_d = fcount_q + 5'd1;
						end else begin
							malformed_d = 1'b1;
						end
					end else begin
						xor_d       = xor_q ^ b;
						r.kind      = KIND_DATA;
						r.data_byte = b;
					end
				end
				PH_CK_HI: begin
					if (!hex[4]) begin
						phase_d       = PH_IDLE;
						emit          = 1'b1;
						r.kind        = KIND_SEND;
						r.field_index = fcount_q;
						r.status      = ST_MALFORMED;
					end else begin
						hi_nib_d = hex[3:0];
						phase_d  = PH_CK_LO;
					end
				end
				PH_CK_LO: begin
					phase_d       = PH_IDLE;
					emit          = 1'b1;
					r.kind        = KIND_SEND;
					r.field_index = fcount_q;
					if (!hex[4] || malformed_q) begin
						r.status = ST_MALFORMED;
					end else if ({hi_nib_q, hex[3:0]} != xor_q) begin
						r.status = ST_CK_BAD;
					end else if (found_q == TYPE_UNKNOWN) begin
						r.status = ST_UNSUPP;
					end else begin
						r.status = ST_OK;
					end
				end
				default: begin
					// Idle: bytes outside a sentence are dropped.
				end
			endcase
		end
		r.sentence_type = found_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			xor_q       <= 8'd0;
			window_q    <= 24'd0;
			found_q     <= TYPE_UNKNOWN;
			fcount_q    <= 5'd0;
			hi_nib_q    <= 4'd0;
			malformed_q <= 1'b0;
			out_valid_q <= 1'b0;
			res_q       <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			xor_q       <= xor_d;
			window_q    <= window_d;
			found_q     <= found_d;
			fcount_q    <= fcount_d;
			hi_nib_q    <= hi_nib_d;
			malformed_q <= malformed_d;
			out_valid_q <= emit;
			if (emit) begin
				res_q <= r;
			end
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The field counter never passes its saturation limit.
	a_fcount_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fcount_q <= FIELD_CAP)
		else $error("field counter above its limit");

	// A comma that ends the address token moves to the fields with index one.
	a_token_comma: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_TYPE && rx.data.rx_byte == CH_COMMA
		|=> phase_q == PH_FIELDS && fcount_q == 5'd1 && out_valid_q)
		else $error("address token comma handled wrongly");

	// The second checksum digit always closes the sentence with a result.
	a_ck_close: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_CK_LO && rx.data.rx_byte != CH_DOLLAR
		|=> phase_q == PH_IDLE && out_valid_q && res_q.kind == KIND_SEND)
		else $error("sentence not closed after checksum");

	// Only data items carry a byte, and only sentence ends carry a status.
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (res_q.kind == KIND_DATA || res_q.data_byte == 8'd0)
			&& (res_q.kind == KIND_SEND || res_q.status == ST_OK))
		else $error("result payload fields not zero");

endmodule

### dv/nmea_sentence_parser_core_tb.sv
`timescale 1ns / 100ps

// Self-checking bench for the NMEA sentence parser core.
//
// Bytes are pushed into the rx channel one item at a time. Each accepted byte is
// handed to a scoreboard object that tracks the parser state on its own (phase,
// running XOR, address window, best sentence type, field counter, checksum high
// digit and the malformed flag) and queues the result item that byte must cause,
// if any. Every result item accepted on the res channel is compared field by field
// against the oldest queued prediction.
//
// The stimulus opens with a few hand-built sentences and then switches to random
// sentences. Most of them are well formed, so that parsing gets through the
// address token, the fields and the checksum. The rest are cut short, carry a
// wrong checksum, a non-hex checksum digit or too many fields, or arrive between
// stray bytes that the parser must ignore.
module nmea_sentence_parser_core_tb;

	import nsp_pkg::*;

	localparam int PARSER_MAX_FIELDS = 31;
	// The field counter is only five bits wide, so it saturates at 31 at most.
	localparam int FIELD_LIMIT = (PARSER_MAX_FIELDS < 31) ? PARSER_MAX_FIELDS : 31;
	localparam int RANDOM_ITEMS = 1400;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 10;
	localparam int CYCLE_LIMIT = 200000;

	// Address codes in priority order; the sentence type is the position plus one.
	localparam logic [23:0] TYPE_TEXT [7] = '{"GGA", "GLL", "GSA", "GSV", "RMC", "VTG", "ZDA"};

	typedef enum logic [2:0] {
		P_IDLE,
		P_ADDR,
		P_FIELDS,
		P_CK_HI,
		P_CK_LO
	} parse_phase_t;

	typedef enum int {
		END_GOOD,
		END_BAD_SUM,
		END_BAD_HI,
		END_BAD_LO,
		END_CUT
	} sentence_end_t;

	// Value of an uppercase hex digit, or -1 for any other byte.
	function automatic int hex_value(input logic [7:0] b);
		if (b >= "0" && b <= "9") begin
			return int'(b) - int'("0");
		end
		if (b >= "A" && b <= "F") begin
			return int'(b) - int'("A") + 10;
		end
		return -1;
	endfunction

	// Tracks the parser state from accepted bytes and checks result items in order.
	class sentence_scoreboard;
		res_item_t    pending[$];
		int           error_count = 0;
		parse_phase_t phase = P_IDLE;
		logic [7:0]   check_xor = '0;
		logic [23:0]  window = '0;
		logic [2:0]   best_type = TYPE_UNKNOWN;
		logic [4:0]   field_no = '0;
		logic [3:0]   hi_digit = '0;
		bit           bad_form = 1'b0;

		function void restart();
			phase = P_IDLE;
			check_xor = '0;
			window = '0;
			best_type = TYPE_UNKNOWN;
			field_no = '0;
			hi_digit = '0;
			bad_form = 1'b0;
		endfunction

		function void queue_result(logic [1:0] kind, logic [7:0] data, logic [4:0] idx,
				logic [1:0] st);
			res_item_t r;
			r.kind = kind;
			r.data_byte = data;
			r.sentence_type = best_type;
			r.field_index = idx;
			r.status = st;
			pending = {pending, r};
		endfunction

		function void note_byte(logic [7:0] b);
			int         digit;
			logic [4:0] idx;
			logic [1:0] st;
			// A start character drops whatever sentence is open.
			if (b == CH_DOLLAR) begin
				restart();
				phase = P_ADDR;
				return;
			end
			case (phase)
				P_ADDR: begin
					if (b == CH_STAR) begin
						phase = P_CK_HI;
						queue_result(KIND_FEND, 8'd0, 5'd0, ST_OK);
					end else begin
						check_xor ^= b;
						if (b == CH_COMMA) begin
							phase = P_FIELDS;
							field_no = 5'd1;
							queue_result(KIND_FEND, 8'd0, 5'd0, ST_OK);
						end else begin
							// The best-priority code seen anywhere in the token wins.
							window = {window[15:0], b};
							for (int i = 0; i < 7; i++) begin
								if (window == TYPE_TEXT[i] &&
										(best_type == TYPE_UNKNOWN || i + 1 < best_type)) begin
									best_type = 3'(i + 1);
								end
							end
						end
					end
				end
				P_FIELDS: begin
					if (b == CH_STAR) begin
						phase = P_CK_HI;
						queue_result(KIND_FEND, 8'd0, field_no, ST_OK);
					end else begin
						check_xor ^= b;
						if (b == CH_COMMA) begin
							idx = field_no;
							if (field_no < FIELD_LIMIT) begin
								field_no++;
							end else begin
								bad_form = 1'b1;
							end
							queue_result(KIND_FEND, 8'd0, idx, ST_OK);
						end else begin
							queue_result(KIND_DATA, b, field_no, ST_OK);
						end
					end
				end
				P_CK_HI: begin
					digit = hex_value(b);
					if (digit < 0) begin
						phase = P_IDLE;
						queue_result(KIND_SEND, 8'd0, field_no, ST_MALFORMED);
					end else begin
						hi_digit = 4'(digit);
						phase = P_CK_LO;
					end
				end
				P_CK_LO: begin
					digit = hex_value(b);
					phase = P_IDLE;
					if (digit < 0 || bad_form) begin
						st = ST_MALFORMED;
					end else if ({hi_digit, 4'(digit)} != check_xor) begin
						st = ST_CK_BAD;
					end else if (best_type == TYPE_UNKNOWN) begin
						st = ST_UNSUPP;
					end else begin
						st = ST_OK;
					end
					queue_result(KIND_SEND, 8'd0, field_no, st);
				end
				default: begin
				end
			endcase
		endfunction

		function void compare(string name, int want, int got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				error_count++;
			end
		endfunction

		function void check_result(res_item_t got);
			res_item_t want;
			if (pending.size() == 0) begin
				$error("result item with nothing expected: kind %0d data %0d", got.kind,
					got.data_byte);
				error_count++;
				return;
			end
			want = pending.pop_front();
			compare("kind", want.kind, got.kind);
			compare("data_byte", want.data_byte, got.data_byte);
			compare("sentence_type", want.sentence_type, got.sentence_type);
			compare("field_index", want.field_index, got.field_index);
			compare("status", want.status, got.status);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	nsp_stream_if #(.payload_t(rx_item_t))  rx_if ();
	nsp_stream_if #(.payload_t(res_item_t)) res_if ();

	nmea_sentence_parser_core #(
		.MAX_FIELDS(PARSER_MAX_FIELDS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_if),
		.res(res_if)
	);

	sentence_scoreboard sentence_sb = new();

	// Idle rates in percent, changed by the stimulus as the run moves through its phases.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	// Raised once by the stimulus to make the receiver stall for a long stretch.
	bit hold_wanted = 1'b0;
	int items_sent = 0;
	int cycle_count = 0;
	logic [7:0] sentence_body[$];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog. A correct run finishes far below this count even with the long stall.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$error("timeout after %0d cycles, %0d results outstanding", cycle_count,
				sentence_sb.pending.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Both handshakes are sampled at the clock edge, before any register updates.
	// The result check goes first: a result taken at this edge always belongs to a
	// byte accepted at an earlier edge, so its prediction is already queued.
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				sentence_sb.check_result(res_if.data);
			end
			if (rx_if.valid && rx_if.ready) begin
				sentence_sb.note_byte(rx_if.data.rx_byte);
			end
		end
	end

	// Receiver. It drops ready at random, and once holds it low for a long stretch so
	// that the result register stays full and the parser has to stall its input.
	initial begin
		int hold_count;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_wanted) begin
				hold_wanted = 1'b0;
				res_if.ready <= 1'b0;
				for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) begin
					@(posedge clk);
				end
			end
			res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Offers one byte and returns at the edge where it is taken. Valid stays high on
	// return, so that a following byte can be offered at once without a gap.
	task automatic send_byte(input logic [7:0] b, input bit counts = 1'b1);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			rx_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		rx_if.valid <= 1'b1;
		rx_if.data.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready) begin
			@(posedge clk);
		end
		if (counts) begin
			items_sent++;
		end
	endtask

	// Appends one byte to the sentence body under construction.
	function automatic void body_add(input logic [7:0] b);
		sentence_body = {sentence_body, b};
	endfunction

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			body_add(s[i]);
		end
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		return (n < 10) ? 8'("0") + 8'(n) : 8'("A") + 8'(n) - 8'd10;
	endfunction

	// Any byte that cannot be a checksum digit, except a start character.
	function automatic logic [7:0] non_hex_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (hex_value(b) >= 0 || b == CH_DOLLAR);
		return b;
	endfunction

	// Any byte a field may carry, mostly printable.
	function automatic logic [7:0] field_byte();
		logic [7:0] b;
		do begin
			if ($urandom_range(0, 99) < 80) begin
				b = 8'($urandom_range(8'h20, 8'h7E));
			end else begin
				b = 8'($urandom_range(0, 255));
			end
		end while (b == CH_DOLLAR || b == CH_STAR || b == CH_COMMA);
		return b;
	endfunction

	function automatic logic [7:0] upper_letter();
		return 8'($urandom_range(8'h41, 8'h5A));
	endfunction

	// Sends a start character, the body, and then the tail that the ending asks for.
	// The checksum covers the body bytes only, as on the wire.
	task automatic send_sentence(input sentence_end_t ending);
		logic [7:0] sum;
		logic [7:0] ck;
		sum = '0;
		send_byte(CH_DOLLAR);
		foreach (sentence_body[i]) begin
			send_byte(sentence_body[i]);
			sum ^= sentence_body[i];
		end
		if (ending == END_CUT) begin
			return;
		end
		send_byte(CH_STAR);
		ck = (ending == END_BAD_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum;
		if (ending == END_BAD_HI) begin
			send_byte(non_hex_byte());
		end else begin
			send_byte(hex_char(ck[7:4]));
			send_byte((ending == END_BAD_LO) ? non_hex_byte() : hex_char(ck[3:0]));
		end
	endtask

	// Builds a random sentence body: an address token of one of several shapes, then
	// a handful of fields, now and then more fields than the counter can hold.
	task automatic send_random_sentence();
		int            shape;
		int            num_fields;
		int            pick;
		sentence_end_t ending;
		sentence_body.delete();
		shape = $urandom_range(0, 9);
		if (shape <= 5) begin
			// Talker prefix followed by a sentence code, the common case.
			body_add(upper_letter());
			body_add(upper_letter());
			add_text(string'(TYPE_TEXT[$urandom_range(0, 6)]));
		end else if (shape == 6) begin
			repeat ($urandom_range(0, 6)) body_add(upper_letter());
		end else if (shape == 7) begin
			// Two codes in one token: the one with higher priority must win.
			add_text(string'(TYPE_TEXT[$urandom_range(0, 6)]));
			add_text(string'(TYPE_TEXT[$urandom_range(0, 6)]));
		end else if (shape == 9) begin
			add_text(string'(TYPE_TEXT[$urandom_range(0, 6)]));
			repeat ($urandom_range(1, 3)) body_add(field_byte());
		end
		num_fields = ($urandom_range(0, 99) < 6) ? $urandom_range(29, 34) : $urandom_range(0, 6);
		repeat (num_fields) begin
			body_add(CH_COMMA);
			repeat ($urandom_range(0, 6)) body_add(field_byte());
		end
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			ending = END_CUT;
		end else if (pick < 74) begin
			ending = END_GOOD;
		end else if (pick < 84) begin
			ending = END_BAD_SUM;
		end else if (pick < 92) begin
			ending = END_BAD_HI;
		end else begin
			ending = END_BAD_LO;
		end
		send_sentence(ending);
	endtask

	initial begin
		arst_n = 1'b0;
		rx_if.valid = 1'b0;
		rx_if.data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 17;
		recv_idle_pct = 64;

		// Stray bytes outside any sentence are ignored, including both byte extremes.
		send_byte(8'h00);
		send_byte(8'hFF);

		// A well-formed GGA sentence whose single field carries both byte extremes.
		sentence_body.delete();
		add_text("GPGGA,");
		body_add(8'hFF);
		body_add(8'h00);
		send_sentence(END_GOOD);

		// A start inside an open sentence restarts it. The token holds two codes and
		// the higher-priority GLL must win over ZDA.
		send_byte(CH_DOLLAR);
		sentence_body.delete();
		add_text("ZDAGLL");
		send_sentence(END_GOOD);

		// An empty token closed by the star, then a non-hex first checksum digit.
		sentence_body.delete();
		send_sentence(END_BAD_HI);

		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (items_sent < RANDOM_ITEMS / 3) begin
				send_idle_pct = 17;
				recv_idle_pct = 64;
			end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 64;
				recv_idle_pct = 17;
			end else begin
				// Entering the last phase: ask once for the long receiver stall while
				// the sender keeps offering bytes back to back.
				if (send_idle_pct != 0) begin
					hold_wanted = 1'b1;
				end
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			if ($urandom_range(0, 99) < 30) begin
				repeat ($urandom_range(1, 3)) begin
					logic [7:0] stray;
					do stray = 8'($urandom_range(0, 255)); while (stray == CH_DOLLAR);
					send_byte(stray, 1'b0);
				end
			end
			send_random_sentence();
		end
		rx_if.valid <= 1'b0;

		while (sentence_sb.pending.size() != 0) begin
			@(posedge clk);
		end
		// A few more cycles so that a stray extra result would still be seen.
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sentence_sb.error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
